@@ design/motor_velocity_limiter_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the motor velocity limiter
// Implication checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MOTOR_VELOCITY_LIMITER_TOP_ASSERT_SVH
`define MOTOR_VELOCITY_LIMITER_TOP_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication
`define MVL_ASSERT_IMP(name, clock, rstn, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("motor velocity limiter: same-cycle check failed");

// Next-cycle implication
`define MVL_ASSERT_NEXT(name, clock, rstn, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("motor velocity limiter: next-cycle check failed");

`else

`define MVL_ASSERT_IMP(name, clock, rstn, ante, cons)
`define MVL_ASSERT_NEXT(name, clock, rstn, ante, cons)

`endif

`endif

@@ design/mvl_pkg.sv @@
// ----------------------------------------------------------------------------
// mvl_pkg
// Widths, reset values and codes shared by the motor velocity limiter.
// ----------------------------------------------------------------------------
package mvl_pkg;

	// Field widths
	localparam int ACTION_W    = 2;
	localparam int JOINT_W     = 4;
	localparam int DATA_W      = 32;
	localparam int CFG_W       = 31;
	localparam int CFG_IDX_W   = 2;
	localparam int TS_W        = 24;
	localparam int JOINT_CMP_W = 7;

	// Default joint count
	localparam int JOINTS_DEFAULT = 12;

	// Register reset values
	localparam logic [CFG_W-1:0] MAX_SPEED_RST = 31'd655360;
	localparam logic [CFG_W-1:0] MAX_POWER_RST = 31'd11796480;
	localparam logic [CFG_W-1:0] CUTOFF_RST    = 31'd6553600;
	localparam logic [TS_W-1:0]  TIME_STEP_RST = 24'd41943;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POWER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd3;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_TRACK    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LIMITS   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_POSITION = 2'd2;

	// Divider step counts (count register loaded with steps minus one)
	localparam logic [4:0] WEIGHT_LAST = 5'd30;
	localparam logic [4:0] LIMIT_LAST  = 5'd31;

endpackage

@@ design/mvl_ram.sv @@
// ----------------------------------------------------------------------------
// mvl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mvl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 12
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/motor_velocity_limiter_top.sv @@
// ----------------------------------------------------------------------------
// motor_velocity_limiter_top
// Per-joint velocity low-pass, power and range clamp, position integration.
// ----------------------------------------------------------------------------
// One transaction at a time: the block is ready only while idle and a new
// transaction is taken while the previous result still waits in the output
// register. A track step runs the filter weight division and, when the
// torque is non-zero and the power limit stays below 2^32, the power limit
// division; limit loads, position loads, the unused action and
// out-of-range joints go straight to the final state. Track steps use the shared
// restoring divider, which retires one quotient bit per cycle (31 steps for
// the filter weight, 32 for the power speed limit), and the shared
// 33x33 multiplier, used four times per track step. Joint state lives in
// three small RAMs; the stored velocities carry a valid bit per joint that
// reset clears, so no clearing pass follows reset.
`include "motor_velocity_limiter_top_assert.svh"

module motor_velocity_limiter_top #(
	parameter int JOINTS = mvl_pkg::JOINTS_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mvl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mvl_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic [mvl_pkg::ACTION_W-1:0]       action,
	input  logic [mvl_pkg::JOINT_W-1:0]        joint,
	input  logic signed [mvl_pkg::DATA_W-1:0]  desired_velocity,
	input  logic signed [mvl_pkg::DATA_W-1:0]  previous_torque,
	input  logic signed [mvl_pkg::DATA_W-1:0]  min_velocity,
	input  logic signed [mvl_pkg::DATA_W-1:0]  max_velocity,
	input  logic signed [mvl_pkg::DATA_W-1:0]  start_position,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic signed [mvl_pkg::DATA_W-1:0]  limited_velocity,
	output logic signed [mvl_pkg::DATA_W-1:0]  joint_position
);

	import mvl_pkg::*;

	localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	localparam logic signed [33:0] POS_MAX = 34'sh0_7FFF_FFFF;
	localparam logic signed [33:0] POS_MIN = 34'sh3_8000_0000;

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_LOAD  = 12'b0000_0000_0010,
		ST_KMUL  = 12'b0000_0000_0100,
		ST_ASET  = 12'b0000_0000_1000,
		ST_DIVA  = 12'b0000_0001_0000,
		ST_MULB  = 12'b0000_0010_0000,
		ST_MULA  = 12'b0000_0100_0000,
		ST_ROUND = 12'b0000_1000_0000,
		ST_DIVL  = 12'b0001_0000_0000,
		ST_CLAMP = 12'b0010_0000_0000,
		ST_PMUL  = 12'b0100_0000_0000,
		ST_DONE  = 12'b1000_0000_0000
	} state_t;

	// Control
	state_t            state_q;
	logic [4:0]        div_cnt_q;
	logic              result_valid_q;
	logic [JOINTS-1:0] vel_vld_q;

	// Configuration registers
	logic [CFG_W-1:0] max_speed_q;
	logic [CFG_W-1:0] max_power_q;
	logic [CFG_W-1:0] cutoff_q;
	logic [TS_W-1:0]  time_step_q;

	// Captured transaction
	logic [ACTION_W-1:0]      act_q;
	logic [JW-1:0]            joint_q;
	logic                     inr_q;
	logic signed [DATA_W-1:0] des_q;
	logic signed [DATA_W-1:0] tq_q;
	logic signed [DATA_W-1:0] min_q;
	logic signed [DATA_W-1:0] max_q;
	logic signed [DATA_W-1:0] spos_q;

	// Joint state read from the RAMs
	logic signed [DATA_W-1:0] vel_q;
	logic signed [DATA_W-1:0] lo_q;
	logic signed [DATA_W-1:0] hi_q;
	logic signed [DATA_W-1:0] pos_q;

	// Working registers
	logic signed [DATA_W-1:0] v_q;
	logic signed [65:0]       prod_q;
	logic signed [63:0]       acc_q;
	logic [55:0]              div_r_q;
	logic [31:0]              div_n_q;
	logic [55:0]              div_d_q;
	logic [31:0]              div_q_q;
	logic signed [DATA_W-1:0] lv_q;
	logic signed [DATA_W-1:0] jp_q;

	// Combinational
	logic                     item_go;
	logic                     in_range;
	logic                     out_free;
	logic                     done_go;
	logic signed [32:0]       mul_a;
	logic signed [32:0]       mul_b;
	logic signed [65:0]       mul_p;
	logic [31:0]              b0;
	logic [56:0]              div_rs;
	logic [57:0]              div_diff;
	logic                     div_ge;
	logic [55:0]              div_r_nx;
	logic [31:0]              div_q_nx;
	logic [31:0]              div_n_nx;
	logic [63:0]              rnd_sum;
	logic [31:0]              tq_abs;
	logic                     lim_sat;
	logic signed [33:0]       lim34;
	logic signed [33:0]       nlim34;
	logic signed [33:0]       v34;
	logic signed [DATA_W-1:0] cl1;
	logic signed [DATA_W-1:0] cl2;
	logic [63:0]              pos_sum;
	logic signed [DATA_W-1:0] delta;
	logic signed [33:0]       np34;
	logic signed [DATA_W-1:0] new_pos;
	logic signed [DATA_W-1:0] res_vel;
	logic signed [DATA_W-1:0] res_pos;

	// RAM ports
	logic [JW-1:0]       rd_addr;
	logic                vel_we;
	logic                pos_we;
	logic                lim_we;
	logic [DATA_W-1:0]   pos_wdata;
	logic [DATA_W-1:0]   vel_rd;
	logic [2*DATA_W-1:0] lim_rd;
	logic [DATA_W-1:0]   pos_rd;

	// Handshakes
	assign item_ready = (state_q == ST_IDLE);
	assign item_go    = item_valid && item_ready;
	assign in_range   = JOINT_CMP_W'(joint) < JOINT_CMP_W'(JOINTS);
	assign out_free   = !result_valid_q || result_ready;
	assign done_go    = (state_q == ST_DONE) && out_free;

	// Shared multiplier operand selection
	assign b0 = 32'h8000_0000 - {1'b0, div_q_q[30:0]};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_KMUL: begin
				mul_a = {9'b0, time_step_q};
				mul_b = {2'b0, cutoff_q};
			end
			ST_MULB: begin
				mul_a = {des_q[31], des_q};
				mul_b = {1'b0, b0};
			end
			ST_MULA: begin
				mul_a = {vel_q[31], vel_q};
				mul_b = {2'b0, div_q_q[30:0]};
			end
			ST_PMUL: begin
				mul_a = {v_q[31], v_q};
				mul_b = {9'b0, time_step_q};
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Shared restoring divider: one quotient bit per step
	assign div_rs   = {div_r_q, div_n_q[31]};
	assign div_diff = {1'b0, div_rs} - {2'b0, div_d_q};
	assign div_ge   = !div_diff[57];
	assign div_r_nx = div_ge ? div_diff[55:0] : div_rs[55:0];
	assign div_q_nx = {div_q_q[30:0], div_ge};
	assign div_n_nx = {div_n_q[30:0], 1'b0};

	// Filter output, rounded half up
	assign rnd_sum = acc_q + prod_q[63:0] + 64'h0000_0000_4000_0000;

	// Torque magnitude; limit saturates once the quotient reaches 2^32
	assign tq_abs  = tq_q[31] ? (~tq_q + 32'd1) : tq_q;
	assign lim_sat = {17'b0, max_power_q[30:16]} >= tq_abs;

	// Power limit, then the joint's own range (upper tested first)
	assign lim34  = {2'b0, div_q_q};
	assign nlim34 = -lim34;
	assign v34    = {{2{v_q[31]}}, v_q};

	always_comb begin
		if (v34 > lim34) begin
			cl1 = lim34[31:0];
		end else if (v34 < nlim34) begin
			cl1 = nlim34[31:0];
		end else begin
			cl1 = v_q;
		end
		if (cl1 > hi_q) begin
			cl2 = hi_q;
		end else if (cl1 < lo_q) begin
			cl2 = lo_q;
		end else begin
			cl2 = cl1;
		end
	end

	// Position step, rounded half up, with saturation
	assign pos_sum = prod_q[63:0] + 64'd8388608;
	assign delta   = pos_sum[55:24];
	assign np34    = {{2{pos_q[31]}}, pos_q} + {{2{delta[31]}}, delta};

	always_comb begin
		if (np34 > POS_MAX) begin
			new_pos = 32'sh7FFF_FFFF;
		end else if (np34 < POS_MIN) begin
			new_pos = 32'sh8000_0000;
		end else begin
			new_pos = np34[31:0];
		end
	end

	// Result selection
	always_comb begin
		res_vel = '0;
		res_pos = '0;
		if (inr_q) begin
			case (act_q)
				ACT_TRACK: begin
					res_vel = v_q;
					res_pos = new_pos;
				end
				ACT_LIMITS: begin
					res_vel = '0;
					res_pos = pos_q;
				end
				ACT_POSITION: begin
					res_vel = vel_q;
					res_pos = spos_q;
				end
				default: begin
					res_vel = vel_q;
					res_pos = pos_q;
				end
			endcase
		end
	end

	// Joint state writes on leaving the final state
	assign vel_we    = done_go && inr_q && (act_q == ACT_TRACK);
	assign lim_we    = done_go && inr_q && (act_q == ACT_LIMITS);
	assign pos_we    = done_go && inr_q && ((act_q == ACT_TRACK) || (act_q == ACT_POSITION));
	assign pos_wdata = (act_q == ACT_TRACK) ? new_pos : spos_q;
	assign rd_addr   = item_ready ? JW'(joint) : joint_q;

	mvl_ram #(
		.WIDTH(DATA_W),
		.DEPTH(JOINTS)
	) u_vel_ram (
		.clk     (clk),
		.wr_en   (vel_we),
		.wr_addr (joint_q),
		.wr_data (v_q),
		.rd_addr (rd_addr),
		.rd_data (vel_rd)
	);

	mvl_ram #(
		.WIDTH(2 * DATA_W),
		.DEPTH(JOINTS)
	) u_lim_ram (
		.clk     (clk),
		.wr_en   (lim_we),
		.wr_addr (joint_q),
		.wr_data ({max_q, min_q}),
		.rd_addr (rd_addr),
		.rd_data (lim_rd)
	);

	mvl_ram #(
		.WIDTH(DATA_W),
		.DEPTH(JOINTS)
	) u_pos_ram (
		.clk     (clk),
		.wr_en   (pos_we),
		.wr_addr (joint_q),
		.wr_data (pos_wdata),
		.rd_addr (rd_addr),
		.rd_data (pos_rd)
	);

	// Sequencer, configuration and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			div_cnt_q      <= '0;
			result_valid_q <= 1'b0;
			vel_vld_q      <= '0;
			max_speed_q    <= MAX_SPEED_RST;
			max_power_q    <= MAX_POWER_RST;
			cutoff_q       <= CUTOFF_RST;
			time_step_q    <= TIME_STEP_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_SPEED: max_speed_q <= cfg_data;
					REG_MAX_POWER: max_power_q <= cfg_data;
					REG_CUTOFF:    cutoff_q    <= cfg_data;
					REG_TIME_STEP: time_step_q <= cfg_data[TS_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (item_go) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= (inr_q && (act_q == ACT_TRACK)) ? ST_KMUL : ST_DONE;
				end
				ST_KMUL: state_q <= ST_ASET;
				ST_ASET: begin
					state_q   <= ST_DIVA;
					div_cnt_q <= WEIGHT_LAST;
				end
				ST_DIVA: begin
					if (div_cnt_q == '0) begin
						state_q <= ST_MULB;
					end else begin
						div_cnt_q <= div_cnt_q - 5'd1;
					end
				end
				ST_MULB:  state_q <= ST_MULA;
				ST_MULA:  state_q <= ST_ROUND;
				ST_ROUND: begin
					if ((tq_q == '0) || lim_sat) begin
						state_q <= ST_CLAMP;
					end else begin
						state_q   <= ST_DIVL;
						div_cnt_q <= LIMIT_LAST;
					end
				end
				ST_DIVL: begin
					if (div_cnt_q == '0) begin
						state_q <= ST_CLAMP;
					end else begin
						div_cnt_q <= div_cnt_q - 5'd1;
					end
				end
				ST_CLAMP: state_q <= ST_PMUL;
				ST_PMUL:  state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			// Hold the result until taken
			if (done_go) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			// Mark stored velocity live on a track step, drop it on a limit load
			if (vel_we) begin
				vel_vld_q[joint_q] <= 1'b1;
			end else if (lim_we) begin
				vel_vld_q[joint_q] <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (item_go) begin
			act_q   <= action;
			joint_q <= JW'(joint);
			inr_q   <= in_range;
			des_q   <= desired_velocity;
			tq_q    <= previous_torque;
			min_q   <= min_velocity;
			max_q   <= max_velocity;
			spos_q  <= start_position;
		end

		case (state_q)
			ST_LOAD: begin
				vel_q <= vel_vld_q[joint_q] ? vel_rd : '0;
				lo_q  <= lim_rd[DATA_W-1:0];
				hi_q  <= lim_rd[2*DATA_W-1:DATA_W];
				pos_q <= pos_rd;
			end
			ST_KMUL, ST_MULB, ST_PMUL: begin
				prod_q <= mul_p;
			end
			ST_MULA: begin
				prod_q <= mul_p;
				acc_q  <= prod_q[63:0];
			end
			ST_ASET: begin
				div_r_q <= prod_q[55:0];
				div_d_q <= 56'(prod_q[54:0]) + (56'd1 << 40);
				div_n_q <= '0;
				div_q_q <= '0;
			end
			ST_DIVA, ST_DIVL: begin
				div_r_q <= div_r_nx;
				div_n_q <= div_n_nx;
				div_q_q <= div_q_nx;
			end
			ST_ROUND: begin
				v_q <= rnd_sum[62:31];
				if (tq_q == '0) begin
					div_q_q <= {1'b0, max_speed_q};
				end else if (lim_sat) begin
					div_q_q <= '1;
				end else begin
					div_r_q <= {41'b0, max_power_q[30:16]};
					div_n_q <= {max_power_q[15:0], 16'b0};
					div_d_q <= {24'b0, tq_abs};
					div_q_q <= '0;
				end
			end
			ST_CLAMP: begin
				v_q <= cl2;
			end
			ST_DONE: begin
				if (out_free) begin
					lv_q <= res_vel;
					jp_q <= res_pos;
				end
			end
			default: ;
		endcase
	end

	assign result_valid     = result_valid_q;
	assign limited_velocity = lv_q;
	assign joint_position   = jp_q;

	// Checks
	`MVL_ASSERT_IMP(a_div_rem_below, clk, arst_n, (state_q == ST_DIVA) || (state_q == ST_DIVL), div_r_q < div_d_q)
	`MVL_ASSERT_NEXT(a_accept_loads, clk, arst_n, item_go, state_q == ST_LOAD)
	`MVL_ASSERT_IMP(a_write_at_done, clk, arst_n, vel_we || pos_we || lim_we, done_go && inr_q)
	`MVL_ASSERT_IMP(a_result_from_done, clk, arst_n, $rose(result_valid_q), $past(state_q == ST_DONE))

endmodule
